// File: design/assert_macros.svh
// Assertion macros used by the file that checks the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define TADC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tadc check failed");

// Condition that must hold in the cycle after the trigger.
`define TADC_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("tadc check failed");

`endif

// File: design/tadc_pkg.sv
// Package with constants, the resistance curve and shared types of the converter.
package tadc_pkg;

  localparam int TABLE_ENTRIES = 241;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam int ADC_W = 10;
  localparam logic [ADC_W-1:0] ADC_MAX = 10'd1023;
  localparam int RS_W = 20;
  localparam int R_W = 22;
  localparam logic [R_W-1:0] R_SAT = 22'h3FFFFF;

  // Divider sizes: dividend, divisor and step count.
  localparam int DVD_W = 34;
  localparam int DSR_W = 18;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] STEPS_RES = 6'd34;
  localparam logic [CNT_W-1:0] STEPS_FRAC = 6'd24;

  // Celsius offset above -40.00 C, in hundredths.
  localparam int COFF_W = 15;
  localparam logic [COFF_W-1:0] COFF_TOP = 15'd24000;

  // Reciprocal of five for values below 2**18.
  localparam logic [15:0] RECIP5 = 16'd52429;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Thermistor resistance in tenths of an ohm, one row per degree from -40 C.
  localparam logic [R_W-1:0] NTC_ROM [TABLE_ENTRIES] = '{
    22'd2772000, 22'd2636000, 22'd2501000, 22'd2368000, 22'd2240000, 22'd2115000,
    22'd1996000, 22'd1881000, 22'd1773000, 22'd1670000,
    22'd1572000, 22'd1481000, 22'd1394000, 22'd1313000, 22'd1237000, 22'd1166000,
    22'd1100000, 22'd1037000, 22'd979000, 22'd925000,
    22'd874300, 22'd827900, 22'd784400, 22'd743600, 22'd705300, 22'd669200,
    22'd635400, 22'd603400, 22'd573300, 22'd545000,
    22'd518200, 22'd492800, 22'd468900, 22'd446200, 22'd424800, 22'd404500,
    22'd385300, 22'd367000, 22'd349700, 22'd333300,
    22'd317700, 22'd302500, 22'd288200, 22'd274500, 22'd261600, 22'd249400,
    22'd237700, 22'd226700, 22'd216200, 22'd206300,
    22'd196800, 22'd187800, 22'd179300, 22'd171200, 22'd163500, 22'd156200,
    22'd149300, 22'd142600, 22'd136300, 22'd130400,
    22'd124700, 22'd119200, 22'd114100, 22'd109100, 22'd104500, 22'd100000,
    22'd95750, 22'd91700, 22'd87840, 22'd84160,
    22'd80640, 22'd77300, 22'd74100, 22'd71060, 22'd68150, 22'd65380,
    22'd62730, 22'd60200, 22'd57780, 22'd55480,
    22'd53270, 22'd51170, 22'd49150, 22'd47230, 22'd45390, 22'd43630,
    22'd41950, 22'd40340, 22'd38800, 22'd37330,
    22'd35920, 22'd34570, 22'd33280, 22'd32040, 22'd30860, 22'd29720,
    22'd28630, 22'd27590, 22'd26590, 22'd25640,
    22'd24720, 22'd23840, 22'd22990, 22'd22180, 22'd21410, 22'd20660,
    22'd19940, 22'd19260, 22'd18600, 22'd17960,
    22'd17350, 22'd16770, 22'd16210, 22'd15670, 22'd15150, 22'd14650,
    22'd14170, 22'd13710, 22'd13260, 22'd12840,
    22'd12430, 22'd12030, 22'd11650, 22'd11280, 22'd10930, 22'd10590,
    22'd10270, 22'd9955, 22'd9654, 22'd9363,
    22'd9083, 22'd8812, 22'd8550, 22'd8297, 22'd8052, 22'd7816,
    22'd7587, 22'd7366, 22'd7152, 22'd6945,
    22'd6744, 22'd6558, 22'd6376, 22'd6199, 22'd6026, 22'd5858,
    22'd5694, 22'd5535, 22'd5380, 22'd5229,
    22'd5083, 22'd4941, 22'd4803, 22'd4669, 22'd4539, 22'd4412,
    22'd4290, 22'd4171, 22'd4055, 22'd3944,
    22'd3835, 22'd3730, 22'd3628, 22'd3530, 22'd3434, 22'd3341,
    22'd3253, 22'd3167, 22'd3083, 22'd3002,
    22'd2924, 22'd2848, 22'd2774, 22'd2702, 22'd2633, 22'd2565,
    22'd2500, 22'd2437, 22'd2375, 22'd2316,
    22'd2258, 22'd2202, 22'd2148, 22'd2095, 22'd2044, 22'd1994,
    22'd1946, 22'd1900, 22'd1855, 22'd1811,
    22'd1769, 22'd1728, 22'd1688, 22'd1650, 22'd1612, 22'd1576,
    22'd1541, 22'd1507, 22'd1474, 22'd1441,
    22'd1410, 22'd1379, 22'd1350, 22'd1321, 22'd1293, 22'd1265,
    22'd1239, 22'd1213, 22'd1187, 22'd1163,
    22'd1139, 22'd1115, 22'd1092, 22'd1070, 22'd1048, 22'd1027,
    22'd1006, 22'd986, 22'd966, 22'd947,
    22'd928, 22'd909, 22'd891, 22'd873, 22'd856, 22'd839,
    22'd822, 22'd806, 22'd790, 22'd774,
    22'd759, 22'd743, 22'd729, 22'd714, 22'd700, 22'd686,
    22'd672, 22'd658, 22'd645, 22'd631, 22'd619
  };

endpackage

// File: design/tadc_if.sv
// Channel interfaces for the sample request, the result and the register write.
interface tadc_adc_if;
  logic                         valid;
  logic                         ready;
  logic [tadc_pkg::ADC_W-1:0]   adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface tadc_temp_if;
  logic                       valid;
  logic                       ready;
  logic [tadc_pkg::R_W-1:0]   resistance_tenth_ohm;
  logic signed [15:0]         temp_c_hundredths;
  logic signed [16:0]         temp_f_hundredths;
  logic                       clamped;
  modport source (output valid, output resistance_tenth_ohm, output temp_c_hundredths,
                  output temp_f_hundredths, output clamped, input ready);
  modport sink (input valid, input resistance_tenth_ohm, input temp_c_hundredths,
                input temp_f_hundredths, input clamped, output ready);
endinterface

interface tadc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tadc_pkg::RS_W-1:0]   series_resistor_ohms;
  modport source (output valid, output series_resistor_ohms, input ready);
  modport sink (input valid, input series_resistor_ohms, output ready);
endinterface

// File: design/thermistor_adc_to_temperature_top.sv
// Top level: thermistor sample to resistance, Celsius and Fahrenheit.
//
//  Channel   Dir  Handshake     Payload
//  in_req    in   valid/ready   adc_sample
//  out_res   out  valid/ready   resistance, Celsius, Fahrenheit, clamped
//  cfg_wr    in   valid/ready   series_resistor_ohms (always ready)
//
// A request passes through the accepting cycle, the resistance division and the
// interpolation fraction in the shared bit-serial divider (each with its completion
// cycle), the binary search of the curve and single sequencing steps before the
// next request is taken. A full-scale sample skips the multiply and the first
// division; a reading off either end of the curve skips the search and the second
// division. Reset is synchronous and active low.
// A new request is taken only while the sequencer is idle; a result waiting on
// the output holds the sequencer at its last step until the output register frees.
module thermistor_adc_to_temperature_top (
  input  logic             clk,
  input  logic             rst_n,
  tadc_adc_if.sink         in_req,
  tadc_temp_if.source      out_res,
  tadc_cfg_if.sink         cfg_wr
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_D1GO, S_D1W, S_RANGE, S_SRCH, S_RDROM,
    S_PREP, S_D2GO, S_D2W, S_FAHR, S_OUT
  } state_t;

  state_t                        state_r;
  logic [tadc_pkg::RS_W-1:0]     rs_r;
  logic [tadc_pkg::ADC_W-1:0]    adc_r;
  logic [tadc_pkg::DVD_W-1:0]    num_r;
  logic [tadc_pkg::R_W-1:0]      r_r;
  logic [tadc_pkg::IDX_W-1:0]    lo_r;
  logic [tadc_pkg::IDX_W-1:0]    hi_r;
  logic [tadc_pkg::R_W-1:0]      romhi_r;
  logic [tadc_pkg::R_W-1:0]      romlo_r;
  logic [23:0]                   n2_r;
  logic [tadc_pkg::DSR_W-1:0]    span_r;
  logic [tadc_pkg::COFF_W-1:0]   coff_r;
  logic                          clamp_r;
  logic [33:0]                   prod_r;
  logic                          out_valid_r;
  logic [tadc_pkg::R_W-1:0]      out_r_r;
  logic signed [15:0]            out_c_r;
  logic signed [16:0]            out_f_r;
  logic                          out_clamp_r;

  tadc_pkg::div_cmd_t            div_cmd;
  tadc_pkg::div_sts_t            div_sts;
  logic [tadc_pkg::DVD_W-1:0]    div_dvd;
  logic [tadc_pkg::DSR_W-1:0]    div_dsr;
  logic [tadc_pkg::DVD_W-1:0]    div_q;

  logic [23:0]                   rs10;
  logic [tadc_pkg::IDX_W:0]      mid_sum;
  logic [tadc_pkg::IDX_W-1:0]    mid;
  logic [tadc_pkg::IDX_W-1:0]    base;
  logic [17:0]                   f9;
  logic                          out_free;

  // Register write port.
  assign cfg_wr.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= 20'd10000;
    end else if (cfg_wr.valid) begin
      rs_r <= cfg_wr.series_resistor_ohms;
    end
  end

  // Helper values for the sequencer.
  always_comb begin
    rs10     = {1'b0, rs_r, 3'b000} + {3'b000, rs_r, 1'b0};
    mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
    mid      = mid_sum[tadc_pkg::IDX_W:1];
    base     = lo_r - 1'b1;
    f9       = {coff_r, 3'b000} + {3'b000, coff_r};
    out_free = !out_valid_r || out_res.ready;
  end

  // Commands and operands for the shared divider.
  always_comb begin
    div_cmd.start = (state_r == S_D1GO) || (state_r == S_D2GO);
    div_cmd.steps = (state_r == S_D1GO) ? tadc_pkg::STEPS_RES : tadc_pkg::STEPS_FRAC;
    if (state_r == S_D1GO) begin
      div_dvd = num_r;
      div_dsr = {8'd0, tadc_pkg::ADC_MAX - adc_r};
    end else begin
      div_dvd = {n2_r, 10'd0};
      div_dsr = span_r;
    end
  end

  tadc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // The output step refills the register itself when it is taken.
      if (out_valid_r && out_res.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            adc_r <= in_req.adc_sample;
            if (in_req.adc_sample >= tadc_pkg::ADC_MAX) begin
              r_r     <= tadc_pkg::R_SAT;
              state_r <= S_RANGE;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          num_r   <= 34'(rs10) * 34'(adc_r);
          state_r <= S_D1GO;
        end
        S_D1GO: state_r <= S_D1W;
        S_D1W: begin
          if (div_sts.done) begin
            r_r     <= (div_q > 34'(tadc_pkg::R_SAT)) ? tadc_pkg::R_SAT
                                                      : div_q[tadc_pkg::R_W-1:0];
            state_r <= S_RANGE;
          end
        end
        S_RANGE: begin
          // Ends of the curve clamp; anything inside is searched.
          if (r_r >= tadc_pkg::NTC_ROM[0]) begin
            coff_r  <= '0;
            clamp_r <= (r_r > tadc_pkg::NTC_ROM[0]);
            state_r <= S_FAHR;
          end else if (r_r <= tadc_pkg::NTC_ROM[tadc_pkg::LAST_IDX]) begin
            coff_r  <= tadc_pkg::COFF_TOP;
            clamp_r <= (r_r < tadc_pkg::NTC_ROM[tadc_pkg::LAST_IDX]);
            state_r <= S_FAHR;
          end else begin
            lo_r    <= 8'd1;
            hi_r    <= tadc_pkg::LAST_IDX;
            clamp_r <= 1'b0;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          // Find the first row at or below the resistance.
          if (lo_r == hi_r) begin
            state_r <= S_RDROM;
          end else if (tadc_pkg::NTC_ROM[mid] <= r_r) begin
            hi_r <= mid;
          end else begin
            lo_r <= mid + 1'b1;
          end
        end
        S_RDROM: begin
          romhi_r <= tadc_pkg::NTC_ROM[base];
          romlo_r <= tadc_pkg::NTC_ROM[lo_r];
          state_r <= S_PREP;
        end
        S_PREP: begin
          n2_r    <= 24'(romhi_r - r_r) * 24'd100;
          span_r  <= tadc_pkg::DSR_W'(romhi_r - romlo_r);
          state_r <= S_D2GO;
        end
        S_D2GO: state_r <= S_D2W;
        S_D2W: begin
          if (div_sts.done) begin
            coff_r  <= 15'(base) * 15'd100 +
                       ((span_r == '0) ? 15'd0 : {8'd0, div_q[6:0]});
            state_r <= S_FAHR;
          end
        end
        S_FAHR: begin
          prod_r  <= 34'(f9) * 34'(tadc_pkg::RECIP5);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_r_r     <= r_r;
            out_c_r     <= $signed({1'b0, coff_r}) - 16'sd4000;
            out_f_r     <= $signed({1'b0, prod_r[33:18]}) - 17'sd4000;
            out_clamp_r <= clamp_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_req.ready                 = (state_r == S_IDLE);
  assign out_res.valid                = out_valid_r;
  assign out_res.resistance_tenth_ohm = out_r_r;
  assign out_res.temp_c_hundredths    = out_c_r;
  assign out_res.temp_f_hundredths    = out_f_r;
  assign out_res.clamped              = out_clamp_r;

  `include "assert_macros.svh"

  `TADC_ASSERT(a_clamp_at_end,
    !(out_valid_r && out_clamp_r) || out_c_r == -16'sd4000 || out_c_r == 16'sd20000)
  `TADC_ASSERT_NEXT(a_full_scale_sat,
    in_req.valid && in_req.ready && in_req.adc_sample == tadc_pkg::ADC_MAX,
    state_r == S_RANGE && r_r == tadc_pkg::R_SAT)
  `TADC_ASSERT(a_offset_range, state_r != S_FAHR || coff_r <= tadc_pkg::COFF_TOP)
  `TADC_ASSERT_NEXT(a_div_started, div_cmd.start, div_sts.busy && !div_sts.done)

endmodule

// File: design/tadc_div.sv
// Restoring divider that produces one quotient bit per clock.
module tadc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tadc_pkg::div_cmd_t            cmd,
  input  logic [tadc_pkg::DVD_W-1:0]    dividend,
  input  logic [tadc_pkg::DSR_W-1:0]    divisor,
  output tadc_pkg::div_sts_t            sts,
  output logic [tadc_pkg::DVD_W-1:0]    quotient
);

  logic [tadc_pkg::CNT_W-1:0] count_r;
  logic                       done_r;
  logic [tadc_pkg::DVD_W-1:0] q_r;
  logic [tadc_pkg::DSR_W-1:0] rem_r;
  logic [tadc_pkg::DSR_W-1:0] dsr_r;
  logic [tadc_pkg::DSR_W:0]   trial;
  logic                       qbit;

  // Shift the next dividend bit into the partial remainder and test it.
  always_comb begin
    trial = {rem_r, q_r[tadc_pkg::DVD_W-1]};
    qbit  = (trial >= {1'b0, dsr_r});
  end

  // The quotient bits shift in at the bottom as the dividend leaves the top.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        count_r <= cmd.steps;
        q_r     <= dividend;
        rem_r   <= '0;
        dsr_r   <= divisor;
      end else if (count_r != '0) begin
        count_r <= count_r - 1'b1;
        done_r  <= (count_r == 6'd1);
        q_r     <= {q_r[tadc_pkg::DVD_W-2:0], qbit};
        rem_r   <= qbit ? tadc_pkg::DSR_W'(trial - {1'b0, dsr_r})
                        : trial[tadc_pkg::DSR_W-1:0];
      end
    end
  end

  assign sts.busy = (count_r != '0);
  assign sts.done = done_r;
  assign quotient = q_r;

endmodule
